// ----- hw/rtl/point_in_polygon_test_macros.svh -----
// ----------------------------------------------------------------------------
// Point-in-polygon test: assertion macros
// Shorthand for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// same-cycle implication
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: package
// Shared constants and types.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int RAY_BITS = 24;
	localparam logic signed [RAY_BITS-1:0] RAY_RESET = 24'sd1000000;

	typedef struct packed {
		logic new_poly;
		logic last;
	} ctl_t;

endpackage

// ----- hw/rtl/pip_edge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: edge crossing unit
// Tests edge a->b against the horizontal segment (px,py)-(rx,py).
// Orientation products are registered; the compare follows the register.
// ----------------------------------------------------------------------------
module pip_edge #(
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [COORD_BITS-1:0]          ax,
	input  logic signed [COORD_BITS-1:0]          ay,
	input  logic signed [COORD_BITS-1:0]          bx,
	input  logic signed [COORD_BITS-1:0]          by,
	input  logic signed [COORD_BITS-1:0]          px,
	input  logic signed [COORD_BITS-1:0]          py,
	input  logic signed [pip_pkg::RAY_BITS-1:0]   rx,
	output logic                                  crosses
);

	localparam int W  = (COORD_BITS > pip_pkg::RAY_BITS) ? COORD_BITS : pip_pkg::RAY_BITS;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] axe, aye, bxe, bye, pxe, pye, rxe;
	logic signed [DW-1:0] dra, dya, dyb, dbx, dby, dpy, dpx, dex;
	logic signed [PW-1:0] m1, m2, m4;
	logic signed [PW-1:0] m1_s2, m2_s2, m4_s2;
	logic                 c1, c2, side_s2;

	assign axe = DW'(ax);
	assign aye = DW'(ay);
	assign bxe = DW'(bx);
	assign bye = DW'(by);
	assign pxe = DW'(px);
	assign pye = DW'(py);
	assign rxe = DW'(rx);

	assign dra = rxe - pxe;
	assign dya = aye - pye;
	assign dyb = bye - pye;
	assign dbx = bxe - axe;
	assign dby = bye - aye;
	assign dpy = pye - aye;
	assign dpx = pxe - axe;
	assign dex = rxe - axe;

	// ray is horizontal: its orientation tests reduce to sign checks
	assign c1 = (dra != '0) && (dya != '0) && (dra[DW-1] == dya[DW-1]);
	assign c2 = (dra != '0) && (dyb != '0) && (dra[DW-1] == dyb[DW-1]);

	assign m1 = PW'(dbx) * PW'(dpy);
	assign m2 = PW'(dby) * PW'(dpx);
	assign m4 = PW'(dby) * PW'(dex);

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2   <= m1;
			m2_s2   <= m2;
			m4_s2   <= m4;
			side_s2 <= c1 ^ c2;
		end
	end

	assign crosses = side_s2 && ((m1_s2 > m2_s2) != (m1_s2 > m4_s2));

endmodule

// ----- hw/rtl/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
// The word for a last vertex passes stage 1, stage 2 and the output register.
// Throughput: one vertex per cycle; the input side stalls only while the
// output register holds a word that is not taken.
// Reset (arst_n low, asynchronous): pipeline empty, next vertex opens a polygon,
// ray_end_x returns to 1000000.
// ----------------------------------------------------------------------------
// Point-in-polygon test: top level
// Crossing-parity test over a vertex stream, three-stage pipeline.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
	parameter int COORD_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic signed [pip_pkg::RAY_BITS-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        vertex_x,
	input  logic signed [COORD_BITS-1:0]        vertex_y,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	input  logic                                last_vertex,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                inside_res
);

	logic signed [pip_pkg::RAY_BITS-1:0] ray_end_x_q, ray_s1;
	logic                                within_q;
	logic signed [COORD_BITS-1:0]        query_x_q, query_y_q, first_x_q, first_y_q;
	logic signed [COORD_BITS-1:0]        prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0]        cur_qx, cur_qy, cur_fx, cur_fy;
	logic signed [COORD_BITS-1:0]        qx_s1, qy_s1, ax_s1, ay_s1;
	logic signed [COORD_BITS-1:0]        bx_s1, by_s1, fx_s1, fy_s1;
	pip_pkg::ctl_t                       ctl_s1, ctl_s2;
	logic                                v_s1, v_s2, hit_s2;
	logic                                parity_q, hit_q, valid_q, inside_q;
	logic                                x0, x1, par_n, hit_n;
	logic                                in_fire, en2, en3, ld2, out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_end_x_q <= pip_pkg::RAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ray_end_x_q <= cfg_data;
		end
	end

	// flow control
	assign out_free = !valid_q || out_ready;
	assign en3      = v_s2 && (!ctl_s2.last || out_free);
	assign ld2      = !v_s2 || en3;
	assign en2      = v_s1 && ld2;
	assign in_ready = !v_s1 || en2;
	assign in_fire  = in_valid && in_ready;

	// polygon state, updated at accept
	assign cur_qx = within_q ? query_x_q : point_x;
	assign cur_qy = within_q ? query_y_q : point_y;
	assign cur_fx = within_q ? first_x_q : vertex_x;
	assign cur_fy = within_q ? first_y_q : vertex_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			within_q  <= 1'b0;
			query_x_q <= '0;
			query_y_q <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
		end else if (in_fire) begin
			within_q  <= !last_vertex;
			query_x_q <= cur_qx;
			query_y_q <= cur_qy;
			first_x_q <= cur_fx;
			first_y_q <= cur_fy;
			prev_x_q  <= vertex_x;
			prev_y_q  <= vertex_y;
		end
	end

	// stage 1: edge operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			qx_s1           <= cur_qx;
			qy_s1           <= cur_qy;
			ax_s1           <= prev_x_q;
			ay_s1           <= prev_y_q;
			bx_s1           <= vertex_x;
			by_s1           <= vertex_y;
			fx_s1           <= cur_fx;
			fy_s1           <= cur_fy;
			ray_s1          <= ray_end_x_q;
			ctl_s1.new_poly <= !within_q;
			ctl_s1.last     <= last_vertex;
		end
	end

	// stage 2: orientation products
	pip_edge #(.COORD_BITS(COORD_BITS)) u_edge_open (
		.clk     (clk),
		.en      (en2),
		.ax      (ax_s1),
		.ay      (ay_s1),
		.bx      (bx_s1),
		.by      (by_s1),
		.px      (qx_s1),
		.py      (qy_s1),
		.rx      (ray_s1),
		.crosses (x0)
	);

	pip_edge #(.COORD_BITS(COORD_BITS)) u_edge_close (
		.clk     (clk),
		.en      (en2),
		.ax      (bx_s1),
		.ay      (by_s1),
		.bx      (fx_s1),
		.by      (fy_s1),
		.px      (qx_s1),
		.py      (qy_s1),
		.rx      (ray_s1),
		.crosses (x1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ctl_s2 <= ctl_s1;
			hit_s2 <= (bx_s1 == qx_s1) && (by_s1 == qy_s1);
		end
	end

	// stage 3: parity and result word
	assign par_n = (ctl_s2.new_poly ? 1'b0 : parity_q ^ x0) ^ (ctl_s2.last & x1);
	assign hit_n = (ctl_s2.new_poly ? 1'b0 : hit_q) | hit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			hit_q    <= 1'b0;
		end else if (en3) begin
			parity_q <= par_n;
			hit_q    <= hit_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en3 && ctl_s2.last) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && ctl_s2.last) begin
			inside_q <= par_n | hit_n;
		end
	end

	assign out_valid  = valid_q;
	assign inside_res = inside_q;

	`include "point_in_polygon_test_macros.svh"

	`PIP_ASSERT_IMP(a_empty_s1_ready, !v_s1, in_ready, "input stalled with stage 1 empty")
	`PIP_ASSERT_IMP(a_word_from_last, $rose(out_valid), $past(v_s2 && ctl_s2.last), "word without a last vertex")
	`PIP_ASSERT_NXT(a_last_closes, in_fire && last_vertex, !within_q, "polygon not closed after last vertex")

endmodule

// ----- dv/point_in_polygon_test_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: testbench
// Streams polygons of vertices through the block with random idles on both
// sides. An internal crossing-parity predictor computes the expected word for
// each closing vertex, and every output word is checked in order. The ray end
// register is rewritten between phases, including its extremes.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;

	localparam int COORD_BITS   = 24;
	localparam int MAX_CYCLES   = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 20;

	typedef logic signed [COORD_BITS-1:0]        coord_t;
	typedef logic signed [pip_pkg::RAY_BITS-1:0] ray_t;

	localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam ray_t   R_MAX = {1'b0, {(pip_pkg::RAY_BITS-1){1'b1}}};
	localparam ray_t   R_MIN = {1'b1, {(pip_pkg::RAY_BITS-1){1'b0}}};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	ray_t   cfg_data = '0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	coord_t vertex_x = '0;
	coord_t vertex_y = '0;
	coord_t point_x = '0;
	coord_t point_y = '0;
	logic   last_vertex = 1'b0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	logic   inside_res;

	// predictor state
	ray_t   ray_end = pip_pkg::RAY_RESET;
	coord_t q_x = '0, q_y = '0, first_x = '0, first_y = '0, prev_x = '0, prev_y = '0;
	bit     parity = 1'b0, on_vertex = 1'b0, open_poly = 1'b0;

	bit     expected_inside[$];
	int     errors = 0;
	int     cycles = 0;
	int     vertices_sent = 0;
	bit     steady = 1'b0;

	point_in_polygon_test #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_vertex(last_vertex),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inside_res (inside_res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("FAIL point_in_polygon_test");
			$finish;
		end
	end

	// collinear counts as clockwise
	function automatic bit turns_left(longint x0, longint y0, longint x1, longint y1,
			longint x2, longint y2);
		return (x1 - x0) * (y2 - y0) > (y1 - y0) * (x2 - x0);
	endfunction

	function automatic bit edge_crosses_ray(longint ax, longint ay, longint bx, longint by);
		longint px, py, ex;
		px = q_x;
		py = q_y;
		ex = ray_end;
		return (turns_left(px, py, ex, py, ax, ay) != turns_left(px, py, ex, py, bx, by)) &&
			(turns_left(ax, ay, bx, by, px, py) != turns_left(ax, ay, bx, by, ex, py));
	endfunction

	function automatic void track_vertex(coord_t vx, coord_t vy, coord_t px, coord_t py,
			bit last);
		if (!open_poly) begin
			q_x = px;
			q_y = py;
			first_x = vx;
			first_y = vy;
			parity = 1'b0;
			on_vertex = 1'b0;
			open_poly = 1'b1;
		end else begin
			parity ^= edge_crosses_ray(prev_x, prev_y, vx, vy);
		end
		if (vx == q_x && vy == q_y)
			on_vertex = 1'b1;
		prev_x = vx;
		prev_y = vy;
		if (last) begin
			parity ^= edge_crosses_ray(vx, vy, first_x, first_y);
			expected_inside.push_back(parity | on_vertex);
			open_poly = 1'b0;
		end
	endfunction

	// receive side: random stalls, in-order check of each word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_inside.size() == 0) begin
				$display("%0t: unexpected word, inside_res=%0b", $realtime, inside_res);
				errors++;
			end else begin
				if (inside_res !== expected_inside[0]) begin
					$display("%0t: inside_res mismatch, expected %0b actual %0b",
						$realtime, expected_inside[0], inside_res);
					errors++;
				end
				void'(expected_inside.pop_front());
			end
		end
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic send_vertex(coord_t vx, coord_t vy, coord_t px, coord_t py, bit last);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		vertex_x    <= vx;
		vertex_y    <= vy;
		point_x     <= px;
		point_y     <= py;
		last_vertex <= last;
		do
			@(posedge clk);
		while (!in_ready);
		track_vertex(vx, vy, px, py, last);
		vertices_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_inside.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_ray_end(ray_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		ray_end = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic coord_t rand_coord(int span);
		if (span == 0)
			return coord_t'($urandom);
		return coord_t'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic send_polygon(int n, int span);
		coord_t px, py, vx, vy;
		px = rand_coord(span);
		py = rand_coord(span);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				vx = px;
				vy = py;
			end else begin
				vx = rand_coord(span);
				vy = rand_coord(span);
				if ($urandom_range(0, 7) == 0)
					vy = py;
			end
			if (i == 0)
				send_vertex(vx, vy, px, py, n == 1);
			else
				send_vertex(vx, vy, coord_t'($urandom), coord_t'($urandom), i == n - 1);
		end
	endtask

	task automatic random_polygons(int count);
		int stop_at, n, span;
		stop_at = vertices_sent + count;
		while (vertices_sent < stop_at) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			case ($urandom_range(0, 3))
				0: span = 0;
				1: span = 8;
				2: span = 100;
				default: span = 2000000;
			endcase
			send_polygon(n, span);
		end
		drain();
	endtask

	task automatic test_directed();
		send_vertex(5, 5, 5, 5, 1'b1);
		send_vertex(C_MAX, C_MIN, 0, 0, 1'b1);
		send_vertex(-10, -10, 0, 0, 1'b0);
		send_vertex(10, -10, C_MAX, C_MIN, 1'b0);
		send_vertex(10, 10, C_MIN, C_MAX, 1'b0);
		send_vertex(-10, 10, -1, -1, 1'b1);
		send_vertex(-10, -10, 20, 0, 1'b0);
		send_vertex(10, -10, 0, 0, 1'b0);
		send_vertex(10, 10, 0, 0, 1'b0);
		send_vertex(-10, 10, 0, 0, 1'b1);
		send_vertex(5, 0, 0, 0, 1'b0);
		send_vertex(-5, 5, C_MIN, C_MIN, 1'b0);
		send_vertex(-5, -5, C_MAX, C_MAX, 1'b1);
		send_vertex(C_MIN, C_MIN, C_MIN, C_MAX, 1'b0);
		send_vertex(C_MAX, C_MIN, 0, 0, 1'b0);
		send_vertex(C_MAX, C_MAX, 0, 0, 1'b0);
		send_vertex(C_MIN, C_MAX, 0, 0, 1'b1);
		send_vertex(C_MIN, C_MIN, 0, 0, 1'b0);
		send_vertex(C_MAX, C_MIN, 0, 0, 1'b0);
		send_vertex(C_MAX, C_MAX, 0, 0, 1'b0);
		send_vertex(C_MIN, C_MAX, 0, 0, 1'b1);
		drain();
	endtask

	task automatic test_default_ray();
		random_polygons(200);
	endtask

	task automatic test_ray_max_no_idle();
		write_ray_end(R_MAX);
		steady = 1'b1;
		random_polygons(150);
		steady = 1'b0;
	endtask

	task automatic test_ray_min();
		write_ray_end(R_MIN);
		random_polygons(150);
	endtask

	task automatic test_ray_zero();
		write_ray_end('0);
		random_polygons(100);
	endtask

	task automatic test_ray_random();
		repeat (4) begin
			write_ray_end(ray_t'($urandom));
			random_polygons(50);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_ray();
		test_ray_max_no_idle();
		test_ray_min();
		test_ray_zero();
		test_ray_random();
		if (errors == 0)
			$display("PASS point_in_polygon_test");
		else
			$display("FAIL point_in_polygon_test");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pip_pkg.sv
hw/rtl/pip_edge.sv
hw/rtl/point_in_polygon_test.sv
dv/point_in_polygon_test_tb.sv
